@@ rtl/sndl_pkg.sv @@
package sndl_pkg;

  localparam int DEFAULT_ENTRIES = 256;
  localparam int NAME_LEN = 11;
  localparam int EXT_POS = 8;
  localparam int LANES = 12;
  localparam int TYPE_LANE = 11;

  localparam logic [7:0] PAD_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;
  localparam logic [7:0] SKIP_MASK = 8'h18;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7A]}) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ rtl/sndl_if.sv @@
interface sndl_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] entry_index;
  logic [3:0] byte_pos;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output entry_index, output byte_pos,
                  output data_byte, input ready);
  modport sink (input valid, input req_type, input entry_index, input byte_pos,
                input data_byte, output ready);
endinterface

interface sndl_res_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] match_index;
  logic       name_too_long;

  modport source (output valid, output found, output match_index, output name_too_long,
                  input ready);
  modport sink (input valid, input found, input match_index, input name_too_long,
                output ready);
endinterface

@@ rtl/sndl_table.sv @@
module sndl_table #(
  parameter int ENTRIES = sndl_pkg::DEFAULT_ENTRIES,
  parameter int AW = 8
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic [3:0]                         wr_lane,
  input  logic [7:0]                         wr_data,
  input  logic [AW-1:0]                      rd_addr,
  output logic [sndl_pkg::LANES-1:0][7:0]    rd_data
);
  import sndl_pkg::*;

  // Each word holds one directory entry: name bytes in lanes 0 to 10, type in lane 11.
  logic [LANES-1:0][7:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/short_name_directory_lookup.sv @@
// Short-name directory lookup. A table write or a name character is one transaction. The
// zero character that ends a name starts a search through the directory memory, which has
// a single read port and delivers one whole entry per cycle; the search covers at most
// min(entry_count, ENTRIES) entries and stops early when a match or an end-of-directory
// entry is met. New transactions wait while a search runs. Table contents are undefined
// after reset and there is no clearing pass; a search must not reach an entry that was
// never written.
module short_name_directory_lookup #(
  parameter int ENTRIES = sndl_pkg::DEFAULT_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  sndl_req_if.sink   req,
  sndl_res_if.source res
);
  import sndl_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (AW > 8) ? AW : 8;

  state_t state, state_next;

  logic [8:0]    entry_count;
  logic [CW-1:0] limit;
  logic [CW-1:0] limit_cfg;
  logic [CW-1:0] scan_cnt;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic [7:0]    qname [NAME_LEN];
  logic [3:0]    qpos;
  logic          ovf;

  logic          hit_found;
  logic [7:0]    hit_idx;
  logic          hit_long;

  logic          res_valid;
  logic          res_found;
  logic [7:0]    res_index;
  logic          res_long;

  logic                  acc_in;
  logic                  is_term;
  logic                  out_free;
  logic                  issue;
  logic                  name_eq;
  logic                  is_end;
  logic                  plain;
  logic                  match;
  logic                  wr_en;
  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         pend_x;
  logic [LANES-1:0][7:0] rd_data;

  assign acc_in   = req.valid && req.ready;
  assign is_term  = acc_in && (req.req_type == REQ_CHAR) && (req.data_byte == NUL_CHAR);
  assign out_free = !res_valid || res.ready;
  assign issue    = (state == ST_SEARCH) && (scan_cnt < limit);
  assign idx_x    = XW'(req.entry_index);
  assign pend_x   = XW'(pend_idx);
  assign limit_cfg = (32'(entry_count) < ENTRIES) ? CW'(entry_count) : CW'(ENTRIES);

  assign wr_en = acc_in && (req.req_type == REQ_WRITE) && (req.byte_pos <= 4'(TYPE_LANE))
                 && (32'(req.entry_index) < ENTRIES);

  sndl_table #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_x[AW-1:0]),
    .wr_lane (req.byte_pos),
    .wr_data (req.data_byte),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    name_eq = 1'b1;
    for (int i = 0; i < NAME_LEN; i++) begin
      if (rd_data[i] != qname[i]) begin
        name_eq = 1'b0;
      end
    end
  end

  assign is_end = (rd_data[0] == NUL_CHAR);
  assign plain  = ((rd_data[TYPE_LANE] & SKIP_MASK) == 8'h00);
  assign match  = !is_end && plain && name_eq;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_term) begin
          if (ovf || (limit_cfg == '0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (pend && (match || is_end || !issue)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qpos <= '0;
      ovf  <= 1'b0;
      for (int i = 0; i < NAME_LEN; i++) begin
        qname[i] <= PAD_CHAR;
      end
    end else if (state == ST_FINISH && out_free) begin
      qpos <= '0;
      ovf  <= 1'b0;
      for (int i = 0; i < NAME_LEN; i++) begin
        qname[i] <= PAD_CHAR;
      end
    end else if (acc_in && req.req_type == REQ_CHAR && req.data_byte != NUL_CHAR) begin
      if (qpos >= 4'(NAME_LEN)) begin
        ovf <= 1'b1;
      end else if (req.data_byte == DOT_CHAR && qpos <= 4'(EXT_POS)) begin
        qpos <= 4'(EXT_POS);
      end else begin
        qname[qpos] <= to_upper(req.data_byte);
        qpos <= qpos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else if (state == ST_IDLE) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
      limit    <= limit_cfg;
    end else if (state == ST_SEARCH) begin
      pend <= issue;
      if (issue) begin
        scan_cnt <= scan_cnt + CW'(1);
        pend_idx <= scan_cnt[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && is_term) begin
      hit_found <= 1'b0;
      hit_idx   <= '0;
      hit_long  <= ovf;
    end else if (state == ST_SEARCH && pend) begin
      hit_found <= match;
      hit_idx   <= match ? pend_x[7:0] : 8'h00;
      hit_long  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      res_found <= hit_found;
      res_index <= hit_idx;
      res_long  <= hit_long;
    end
  end

  assign req.ready         = (state == ST_IDLE);
  assign res.valid         = res_valid;
  assign res.found         = res_found;
  assign res.match_index   = res_index;
  assign res.name_too_long = res_long;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req.ready)
    else $error("input accepted while a search is in progress");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (scan_cnt <= limit))
    else $error("scan counter passed the search limit");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_FINISH))
    else $error("result appeared without a finished search");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (res_valid && state == ST_IDLE))
    else $error("finished search did not load the output register");

  a_long_not_found: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_long) |-> (!res_found && res_index == 8'h00))
    else $error("overflowed name reported a match");

endmodule
